// ===== rtl/dsc_pkg.sv =====
// dsc_pkg: constants, status codes and month tables for the date span calculator.
// Self-contained; imported by date_span_calculator.
package dsc_pkg;

   // Field widths
   localparam int unsigned DAY_W   = 5;
   localparam int unsigned MONTH_W = 4;
   localparam int unsigned YEAR_W  = 14;
   localparam int unsigned DN_W    = 24;   // day number and signed differences
   localparam int unsigned DAYS_W  = 23;
   localparam int unsigned WEEKS_W = 20;

   // Highest accepted year (1..9999)
   localparam int unsigned MAX_YEAR = 9999;

   // Saturation limits of the signed outputs
   localparam logic signed [DN_W-1:0] DAYS_LIM  = DN_W'(4194303);
   localparam logic signed [DN_W-1:0] WEEKS_LIM = DN_W'(524287);

   // Multiplicative inverse of 7 modulo 2^24, used for exact division by 7
   localparam logic [DN_W-1:0] INV7 = 24'hDB6DB7;

   // Date status codes
   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_BAD_DAY   = 2'd1,
      STATUS_BAD_MONTH = 2'd2
   } status_type;

   // Days in month, February given as 28 (leap day added separately)
   function automatic logic [4:0] month_len(input logic [MONTH_W-1:0] m);
      logic [4:0] len;
      case (m)
         4'd2:    len = 5'd28;
         4'd4:    len = 5'd30;
         4'd6:    len = 5'd30;
         4'd9:    len = 5'd30;
         4'd11:   len = 5'd30;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

   // (153*mm - 457)/5 with January and February as months 13 and 14
   function automatic logic [8:0] month_days(input logic [MONTH_W-1:0] m);
      logic [8:0] v;
      case (m)
         4'd1:    v = 9'd306;
         4'd2:    v = 9'd337;
         4'd3:    v = 9'd0;
         4'd4:    v = 9'd31;
         4'd5:    v = 9'd61;
         4'd6:    v = 9'd92;
         4'd7:    v = 9'd122;
         4'd8:    v = 9'd153;
         4'd9:    v = 9'd184;
         4'd10:   v = 9'd214;
         4'd11:   v = 9'd245;
         4'd12:   v = 9'd275;
         default: v = 9'd0;
      endcase
      return v;
   endfunction

   // 13*(mm+1)/5 Zeller month term, same month shift
   function automatic logic [5:0] month_zeller(input logic [MONTH_W-1:0] m);
      logic [5:0] v;
      case (m)
         4'd1:    v = 6'd36;
         4'd2:    v = 6'd39;
         4'd3:    v = 6'd10;
         4'd4:    v = 6'd13;
         4'd5:    v = 6'd15;
         4'd6:    v = 6'd18;
         4'd7:    v = 6'd20;
         4'd8:    v = 6'd23;
         4'd9:    v = 6'd26;
         4'd10:   v = 6'd28;
         4'd11:   v = 6'd31;
         4'd12:   v = 6'd33;
         default: v = 6'd0;
      endcase
      return v;
   endfunction

   // Days forward to the Monday on or after a date: (9 - w) mod 7
   function automatic logic [2:0] to_monday(input logic [2:0] w);
      logic [2:0] a;
      case (w)
         3'd0:    a = 3'd2;
         3'd1:    a = 3'd1;
         3'd2:    a = 3'd0;
         3'd3:    a = 3'd6;
         3'd4:    a = 3'd5;
         3'd5:    a = 3'd4;
         3'd6:    a = 3'd3;
         default: a = 3'd0;
      endcase
      return a;
   endfunction

endpackage

// ===== rtl/date_span_calculator.sv =====
// date_span_calculator: validates two Gregorian dates, gives their weekdays,
// the day difference and the whole weeks between the following Mondays.
// Depends on dsc_pkg.
//
//  channel | ports   | direction | contents
//  --------+---------+-----------+----------------------------------------------
//  request | req_*   | in        | day, month, year of the first and second date
//  response| rsp_*   | out       | statuses, weekdays, days_between, weeks_between
//
// Seven register stages; a transaction enters every cycle while req_ready is high,
// and its response is valid on rsp_* from the last stage register. The multiplies
// (reciprocal divides by 100 and 7, day count by 365, exact divide of the Monday
// gap by 7) set the stage split.
// The whole pipeline advances when the output stage is empty or taken, so a
// stall freezes every stage in place. Reset clears the stage valid bits only.
module date_span_calculator (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [4:0]          req_first_day,
   input  logic [3:0]          req_first_month,
   input  logic [13:0]         req_first_year,
   input  logic [4:0]          req_second_day,
   input  logic [3:0]          req_second_month,
   input  logic [13:0]         req_second_year,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_first_status,
   output logic [1:0]          rsp_second_status,
   output logic [2:0]          rsp_first_weekday,
   output logic [2:0]          rsp_second_weekday,
   output logic signed [22:0]  rsp_days_between,
   output logic signed [19:0]  rsp_weeks_between
);
   import dsc_pkg::*;

   // Stage 1: decoded month, shifted year and centuries
   typedef struct packed {
      logic [DAY_W-1:0]   day;
      logic [MONTH_W-1:0] month;
      logic [YEAR_W-1:0]  year;
      logic [YEAR_W-1:0]  yy;      // March-based year
      logic [7:0]         cent;    // yy / 100
      logic [7:0]         ycent;   // year / 100
      logic               mon_ok;
      logic               yr_ok;
      logic [8:0]         mdays;
      logic [5:0]         mzel;
   } s1_type;

   // Stage 2: status and day number
   typedef struct packed {
      status_type         status;
      logic [DN_W-1:0]    dn;
      logic [6:0]         rem;     // yy mod 100
      logic [7:0]         cent;
      logic [DAY_W-1:0]   day;
      logic [5:0]         mzel;
   } s2_type;

   logic        adv;
   logic [6:0]  vld_ff;

   s1_type      s1_in [2];
   s1_type      s1_ff [2];
   s2_type      s2_in [2];
   s2_type      s2_ff [2];

   logic [DAY_W-1:0]   in_day   [2];
   logic [MONTH_W-1:0] in_month [2];
   logic [YEAR_W-1:0]  in_year  [2];

   // Stage 3..7 registers
   status_type             st3_ff [2];
   logic [9:0]             zsum_in [2];
   logic [9:0]             zsum_ff [2];
   logic signed [DN_W-1:0] diff3_in, diff3_ff;

   status_type             st4_ff [2];
   logic [2:0]             wd4_in [2];
   logic [2:0]             wd4_ff [2];
   logic signed [DN_W-1:0] diff4_ff;

   logic [1:0]             st5_ff [2];
   logic [2:0]             wd5_in [2];
   logic [2:0]             wd5_ff [2];
   logic signed [DN_W-1:0] gap5_in, gap5_ff;
   logic signed [DN_W-1:0] diff5_in, diff5_ff;

   logic [1:0]             st6_ff [2];
   logic [2:0]             wd6_ff [2];
   logic signed [DN_W-1:0] wk6_in, wk6_ff;
   logic signed [DN_W-1:0] days6_in, days6_ff;

   logic signed [DN_W-1:0] wk7_sat;
   logic [1:0]             st7_ff [2];
   logic [2:0]             wd7_ff [2];
   logic signed [DAYS_W-1:0]  days7_ff;
   logic signed [WEEKS_W-1:0] wk7_ff;

   // Advance all stages when the output register is free
   assign adv       = !vld_ff[6] || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = vld_ff[6];

   assign in_day[0]   = req_first_day;
   assign in_month[0] = req_first_month;
   assign in_year[0]  = req_first_year;
   assign in_day[1]   = req_second_day;
   assign in_month[1] = req_second_month;
   assign in_year[1]  = req_second_year;

   // Stage 1: shift the year, look up month terms, divide years by 100
   always_comb begin
      logic [26:0] cprod;
      logic [26:0] yprod;
      for (int i = 0; i < 2; i++) begin
         s1_in[i].day    = in_day[i];
         s1_in[i].month  = in_month[i];
         s1_in[i].year   = in_year[i];
         s1_in[i].yy     = (in_month[i] < 4'd3) ? in_year[i] - 14'd1 : in_year[i];
         cprod           = 27'(s1_in[i].yy) * 27'd5243;
         yprod           = 27'(in_year[i]) * 27'd5243;
         s1_in[i].cent   = cprod[26:19];
         s1_in[i].ycent  = yprod[26:19];
         s1_in[i].mon_ok = (in_month[i] != 4'd0) && (in_month[i] <= 4'd12);
         s1_in[i].yr_ok  = (in_year[i] != 14'd0) && (17'(in_year[i]) <= 17'(MAX_YEAR));
         s1_in[i].mdays  = month_days(in_month[i]);
         s1_in[i].mzel   = month_zeller(in_month[i]);
      end
   end

   // Stage 2: leap year, status, day number
   always_comb begin
      logic [YEAR_W-1:0] yrem;
      logic              leap;
      logic [4:0]        mlen;
      for (int i = 0; i < 2; i++) begin
         yrem = s1_ff[i].year - 14'(s1_ff[i].ycent * 7'd100);
         leap = (yrem == 14'd0) ? (s1_ff[i].ycent[1:0] == 2'd0)
                                : (s1_ff[i].year[1:0] == 2'd0);
         mlen = month_len(s1_ff[i].month) +
                5'((s1_ff[i].month == 4'd2) && leap);
         if (!s1_ff[i].mon_ok) begin
            s2_in[i].status = STATUS_BAD_MONTH;
         end else if (!s1_ff[i].yr_ok || s1_ff[i].day == 5'd0 || s1_ff[i].day > mlen) begin
            s2_in[i].status = STATUS_BAD_DAY;
         end else begin
            s2_in[i].status = STATUS_OK;
         end
         s2_in[i].dn   = DN_W'(s1_ff[i].yy * 9'd365) + DN_W'(s1_ff[i].yy >> 2)
                       - DN_W'(s1_ff[i].cent) + DN_W'(s1_ff[i].cent >> 2)
                       + DN_W'(s1_ff[i].mdays) + DN_W'(s1_ff[i].day) - DN_W'(306);
         s2_in[i].rem  = 7'(s1_ff[i].yy - 14'(s1_ff[i].cent * 7'd100));
         s2_in[i].cent = s1_ff[i].cent;
         s2_in[i].day  = s1_ff[i].day;
         s2_in[i].mzel = s1_ff[i].mzel;
      end
   end

   // Stage 3: Zeller sum offset to stay non-negative, day number difference
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         zsum_in[i] = 10'(s2_ff[i].mzel) + 10'(s2_ff[i].rem >> 2)
                    + 10'(s2_ff[i].cent >> 2) + 10'(s2_ff[i].day)
                    + 10'(s2_ff[i].rem) - 10'({s2_ff[i].cent, 1'b0}) + 10'd350;
      end
      diff3_in = $signed(s2_ff[1].dn - s2_ff[0].dn);
   end

   // Stage 4: Zeller sum mod 7 by reciprocal multiply
   always_comb begin
      logic [23:0] qprod;
      for (int i = 0; i < 2; i++) begin
         qprod     = 24'(zsum_ff[i]) * 24'd9363;
         wd4_in[i] = 3'(zsum_ff[i] - 10'(qprod[23:16] * 4'd7));
      end
   end

   // Stage 5: mask invalid dates, Monday-to-Monday gap
   always_comb begin
      logic both_ok;
      both_ok = (st4_ff[0] == STATUS_OK) && (st4_ff[1] == STATUS_OK);
      for (int i = 0; i < 2; i++) begin
         wd5_in[i] = (st4_ff[i] == STATUS_OK) ? wd4_ff[i] : 3'd0;
      end
      gap5_in  = both_ok ? diff4_ff + DN_W'(to_monday(wd4_ff[1]))
                                    - DN_W'(to_monday(wd4_ff[0]))
                         : '0;
      diff5_in = both_ok ? diff4_ff : '0;
   end

   // Stage 6: exact divide of the gap by 7, saturate the day difference
   always_comb begin
      wk6_in = $signed(DN_W'(gap5_ff * INV7));
      if (diff5_ff > DAYS_LIM) begin
         days6_in = DAYS_LIM;
      end else if (diff5_ff < -DAYS_LIM) begin
         days6_in = -DAYS_LIM;
      end else begin
         days6_in = diff5_ff;
      end
   end

   // Stage 7 input: saturate the week count
   always_comb begin
      if (wk6_ff > WEEKS_LIM) begin
         wk7_sat = WEEKS_LIM;
      end else if (wk6_ff < -WEEKS_LIM) begin
         wk7_sat = -WEEKS_LIM;
      end else begin
         wk7_sat = wk6_ff;
      end
   end

   // Valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[5:0], req_valid};
      end
   end

   // Payload registers, held while stalled
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 2; i++) begin
            s1_ff[i]   <= s1_in[i];
            s2_ff[i]   <= s2_in[i];
            st3_ff[i]  <= s2_ff[i].status;
            zsum_ff[i] <= zsum_in[i];
            st4_ff[i]  <= st3_ff[i];
            wd4_ff[i]  <= wd4_in[i];
            st5_ff[i]  <= st4_ff[i];
            wd5_ff[i]  <= wd5_in[i];
            st6_ff[i]  <= st5_ff[i];
            wd6_ff[i]  <= wd5_ff[i];
            st7_ff[i]  <= st6_ff[i];
            wd7_ff[i]  <= wd6_ff[i];
         end
         diff3_ff <= diff3_in;
         diff4_ff <= diff3_ff;
         gap5_ff  <= gap5_in;
         diff5_ff <= diff5_in;
         wk6_ff   <= wk6_in;
         days6_ff <= days6_in;
         days7_ff <= DAYS_W'(days6_ff);
         wk7_ff   <= WEEKS_W'(wk7_sat);
      end
   end

   assign rsp_first_status   = st7_ff[0];
   assign rsp_second_status  = st7_ff[1];
   assign rsp_first_weekday  = wd7_ff[0];
   assign rsp_second_weekday = wd7_ff[1];
   assign rsp_days_between   = days7_ff;
   assign rsp_weeks_between  = wk7_ff;

endmodule
